[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the sphere merge RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked every clock outside reset
`define BSM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define BSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/core/bsm_pkg.sv]
// ----------------------------------------------------------------------------
// bsm_pkg
// Widths, beat types and side-band structs for the sphere merge pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsm_pkg;

    localparam int AXES      = 3;
    localparam int CW        = 24;      // coordinate / radius width
    localparam int DW        = 25;      // distance (sqrt result) width
    localparam int D2W       = 50;      // squared distance width
    localparam int KW        = 26;      // scale and divisor width
    localparam int NW        = 51;      // dividend width
    localparam int QW        = 25;      // quotient width
    localparam int RW        = 26;      // unsaturated merged radius width
    localparam int GW        = 48;      // growth width
    localparam int SQ_REMW   = 27;      // sqrt remainder width
    localparam int SQ_STAGES = DW;
    localparam int DV_STAGES = QW;

    typedef logic [AXES-1:0][CW-1:0] coord3_t;

    typedef struct packed {
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [CW-1:0] a_z;
        logic [CW-1:0]        a_r;
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] b_y;
        logic signed [CW-1:0] b_z;
        logic [CW-1:0]        b_r;
    } in_beat_t;

    typedef struct packed {
        logic signed [CW-1:0] m_x;
        logic signed [CW-1:0] m_y;
        logic signed [CW-1:0] m_z;
        logic [CW-1:0]        m_r;
        logic                 overlap;
        logic [GW-1:0]        growth;
        logic                 saturated;
    } out_beat_t;

    typedef struct packed {
        coord3_t             a;
        coord3_t             b;
        coord3_t             mag;
        logic [AXES-1:0]     neg;
        logic [CW-1:0]       ar;
        logic [CW-1:0]       br;
        logic                overlap;
        logic                contain;
    } sq_side_t;

    typedef struct packed {
        coord3_t             a;
        coord3_t             b;
        logic [AXES-1:0]     neg;
        logic                overlap;
        logic                contain;
        logic                a_wins;
        logic [RW-1:0]       rad;
        logic [D2W-1:0]      rad2;
        logic [2*CW-1:0]     ar2;
    } dv_side_t;

endpackage

[rtl/core/bsm_front.sv]
// ----------------------------------------------------------------------------
// bsm_front
// Input register, centre deltas, squares, squared distance and the
// containment and overlap compares. Four register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsm_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_vld,
    input  bsm_pkg::in_beat_t        in_beat,
    output logic                     out_vld,
    output logic [bsm_pkg::D2W-1:0]  dist2,
    output bsm_pkg::sq_side_t        side
);
    import bsm_pkg::*;

    logic                        v1_reg, v2_reg, v3_reg, v4_reg;
    in_beat_t                    beat_reg;
    sq_side_t                    side2_reg, side2_next;
    sq_side_t                    side3_reg;
    sq_side_t                    side4_reg, side4_next;
    logic [CW-1:0]               rdiff_reg, rdiff_next;
    logic [CW:0]                 rsum_reg, rsum_next;
    logic [AXES-1:0][2*CW-1:0]   mag2_reg, mag2_next;
    logic [2*CW-1:0]             rdiff2_reg, rdiff2_next;
    logic [D2W-1:0]              rsum2_reg, rsum2_next;
    logic [D2W-1:0]              dist2_reg, dist2_next;

    // stage 2: deltas and magnitudes
    always_comb
    begin
        logic signed [CW:0] d;
        logic signed [CW:0] dabs;
        side2_next         = '0;
        side2_next.a[0]    = beat_reg.a_x;
        side2_next.a[1]    = beat_reg.a_y;
        side2_next.a[2]    = beat_reg.a_z;
        side2_next.b[0]    = beat_reg.b_x;
        side2_next.b[1]    = beat_reg.b_y;
        side2_next.b[2]    = beat_reg.b_z;
        side2_next.ar      = beat_reg.a_r;
        side2_next.br      = beat_reg.b_r;
        for (int i = 0; i < AXES; i++)
        begin
            d = $signed({side2_next.b[i][CW-1], side2_next.b[i]})
                - $signed({side2_next.a[i][CW-1], side2_next.a[i]});
            dabs = d[CW] ? -d : d;
            side2_next.neg[i] = d[CW];
            side2_next.mag[i] = dabs[CW-1:0];
        end
        rdiff_next = (beat_reg.a_r > beat_reg.b_r) ? beat_reg.a_r - beat_reg.b_r
                                                   : beat_reg.b_r - beat_reg.a_r;
        rsum_next  = {1'b0, beat_reg.a_r} + {1'b0, beat_reg.b_r};
    end

    // stage 3: squares
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            mag2_next[i] = {{CW{1'b0}}, side2_reg.mag[i]} * {{CW{1'b0}}, side2_reg.mag[i]};
        end
        rdiff2_next = {{CW{1'b0}}, rdiff_reg} * {{CW{1'b0}}, rdiff_reg};
        rsum2_next  = {{(D2W-CW-1){1'b0}}, rsum_reg} * {{(D2W-CW-1){1'b0}}, rsum_reg};
    end

    // stage 4: sum and compares
    always_comb
    begin
        dist2_next         = D2W'(mag2_reg[0]) + D2W'(mag2_reg[1]) + D2W'(mag2_reg[2]);
        side4_next         = side3_reg;
        side4_next.contain = D2W'(rdiff2_reg) >= dist2_next;
        side4_next.overlap = dist2_next < rsum2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg   <= in_beat;
        side2_reg  <= side2_next;
        rdiff_reg  <= rdiff_next;
        rsum_reg   <= rsum_next;
        side3_reg  <= side2_reg;
        mag2_reg   <= mag2_next;
        rdiff2_reg <= rdiff2_next;
        rsum2_reg  <= rsum2_next;
        side4_reg  <= side4_next;
        dist2_reg  <= dist2_next;
    end

    assign out_vld = v4_reg;
    assign dist2   = dist2_reg;
    assign side    = side4_reg;

endmodule

[rtl/core/bsm_sqrt.sv]
// ----------------------------------------------------------------------------
// bsm_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsm_sqrt (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_vld,
    input  logic [bsm_pkg::D2W-1:0]  rad,
    input  bsm_pkg::sq_side_t        in_side,
    output logic                     out_vld,
    output logic [bsm_pkg::DW-1:0]   root,
    output bsm_pkg::sq_side_t        out_side
);
    import bsm_pkg::*;

    logic [SQ_STAGES:0]  vld_p;
    logic [D2W-1:0]      rad_p  [SQ_STAGES+1];
    logic [SQ_REMW-1:0]  rem_p  [SQ_STAGES+1];
    logic [DW-1:0]       root_p [SQ_STAGES+1];
    sq_side_t            side_p [SQ_STAGES+1];

    assign vld_p[0]  = in_vld;
    assign rad_p[0]  = rad;
    assign rem_p[0]  = '0;
    assign root_p[0] = '0;
    assign side_p[0] = in_side;

    for (genvar j = 0; j < SQ_STAGES; j++)
    begin : g_stage
        logic [SQ_REMW+1:0] rem_sh;
        logic [SQ_REMW+1:0] trial;
        logic               ge;

        assign rem_sh = {rem_p[j], rad_p[j][D2W-1 -: 2]};
        assign trial  = {2'b00, root_p[j], 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_p[j+1] <= 1'b0;
            end
            else
            begin
                vld_p[j+1] <= vld_p[j];
            end
        end

        always_ff @(posedge clk)
        begin
            rad_p[j+1]  <= {rad_p[j][D2W-3:0], 2'b00};
            rem_p[j+1]  <= ge ? SQ_REMW'(rem_sh - trial) : SQ_REMW'(rem_sh);
            root_p[j+1] <= {root_p[j][DW-2:0], ge};
            side_p[j+1] <= side_p[j];
        end
    end

    assign out_vld  = vld_p[SQ_STAGES];
    assign root     = root_p[SQ_STAGES];
    assign out_side = side_p[SQ_STAGES];

    // remainder of a floor root never exceeds twice the root
    `BSM_ASSERT_IMP(a_sqrt_rem, clk, rst_n, out_vld, rem_p[SQ_STAGES] <= {1'b0, root, 1'b0}, "sqrt remainder out of range")

endmodule

[rtl/core/bsm_div.sv]
// ----------------------------------------------------------------------------
// bsm_div
// Three-lane pipelined restoring divider with a shared divisor, one
// quotient bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsm_div (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_vld,
    input  logic [bsm_pkg::AXES-1:0][bsm_pkg::NW-1:0] num,
    input  logic [bsm_pkg::KW-1:0]                 den,
    input  bsm_pkg::dv_side_t                      in_side,
    output logic                                   out_vld,
    output logic [bsm_pkg::AXES-1:0][bsm_pkg::QW-1:0] quo,
    output bsm_pkg::dv_side_t                      out_side
);
    import bsm_pkg::*;

    logic [DV_STAGES:0]            vld_p;
    logic [AXES-1:0][KW-1:0]       rem_p  [DV_STAGES+1];
    logic [AXES-1:0][QW-1:0]       nq_p   [DV_STAGES+1];
    logic [KW-1:0]                 den_p  [DV_STAGES+1];
    dv_side_t                      side_p [DV_STAGES+1];

    assign vld_p[0]  = in_vld;
    assign den_p[0]  = den;
    assign side_p[0] = in_side;

    for (genvar l = 0; l < AXES; l++)
    begin : g_load
        assign rem_p[0][l] = num[l][NW-1:QW];
        assign nq_p[0][l]  = num[l][QW-1:0];
    end

    for (genvar j = 0; j < DV_STAGES; j++)
    begin : g_stage
        logic [AXES-1:0][KW-1:0] rem_next;
        logic [AXES-1:0][QW-1:0] nq_next;

        always_comb
        begin
            logic [KW:0] rem_sh;
            logic        ge;
            for (int l = 0; l < AXES; l++)
            begin
                rem_sh      = {rem_p[j][l], nq_p[j][l][QW-1]};
                ge          = rem_sh >= {1'b0, den_p[j]};
                rem_next[l] = ge ? KW'(rem_sh - {1'b0, den_p[j]}) : KW'(rem_sh);
                nq_next[l]  = {nq_p[j][l][QW-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_p[j+1] <= 1'b0;
            end
            else
            begin
                vld_p[j+1] <= vld_p[j];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_p[j+1]  <= rem_next;
            nq_p[j+1]   <= nq_next;
            den_p[j+1]  <= den_p[j];
            side_p[j+1] <= side_p[j];
        end
    end

    assign out_vld  = vld_p[DV_STAGES];
    assign quo      = nq_p[DV_STAGES];
    assign out_side = side_p[DV_STAGES];

    `BSM_ASSERT_IMP(a_div_rem, clk, rst_n, out_vld, (rem_p[DV_STAGES][0] < den_p[DV_STAGES]) && (rem_p[DV_STAGES][1] < den_p[DV_STAGES]) && (rem_p[DV_STAGES][2] < den_p[DV_STAGES]), "divider remainder not below divisor")

endmodule

[rtl/core/bounding_sphere_merge_unit.sv]
// ----------------------------------------------------------------------------
// bounding_sphere_merge_unit
// Smallest sphere enclosing two spheres, with overlap flag and growth.
//
//   channel  | ports                 | handshake
//   ---------+-----------------------+-----------------------------------
//   request  | start, busy, req      | beat taken when start && !busy
//   response | done, rsp             | one-cycle strobe, no back-pressure
//
// Fully pipelined: one beat per cycle; a result leaves through the register stages
// (front 4, square root 25, scale 2, divider 25, output 1) after acceptance.
// busy is never raised; nothing in the pipe waits on anything.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bounding_sphere_merge_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  bsm_pkg::in_beat_t    req,
    output logic                 done,
    output bsm_pkg::out_beat_t   rsp
);
    import bsm_pkg::*;

    logic            fr_vld;
    logic [D2W-1:0]  fr_dist2;
    sq_side_t        fr_side;
    logic            sq_vld;
    logic [DW-1:0]   sq_root;
    sq_side_t        sq_side;

    logic            p1_vld_reg;
    logic [KW-1:0]   p1_k_reg, p1_k_next;
    logic [KW-1:0]   p1_den_reg, p1_den_next;
    logic [DW-1:0]   p1_dist_reg, p1_dist_next;
    logic [RW-1:0]   p1_rad_reg, p1_rad_next;
    logic            p1_awin_reg, p1_awin_next;
    sq_side_t        p1_side_reg;

    logic                     p2_vld_reg;
    logic [AXES-1:0][NW-1:0]  p2_num_reg, p2_num_next;
    logic [KW-1:0]            p2_den_reg;
    dv_side_t                 p2_side_reg, p2_side_next;

    logic                     dv_vld;
    logic [AXES-1:0][QW-1:0]  dv_quo;
    dv_side_t                 dv_side;

    logic       done_reg;
    out_beat_t  rsp_reg, rsp_next;

    assign busy = 1'b0;

    bsm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (start && !busy),
        .in_beat (req),
        .out_vld (fr_vld),
        .dist2   (fr_dist2),
        .side    (fr_side)
    );

    bsm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (fr_vld),
        .rad      (fr_dist2),
        .in_side  (fr_side),
        .out_vld  (sq_vld),
        .root     (sq_root),
        .out_side (sq_side)
    );

    // scale factor, divisor and merged radius
    always_comb
    begin
        logic [KW:0] ksum;
        logic [KW:0] rsum;
        ksum = {2'b00, sq_root} + {3'b000, sq_side.br} - {3'b000, sq_side.ar};
        rsum = {2'b00, sq_root} + {3'b000, sq_side.ar} + {3'b000, sq_side.br};
        p1_awin_next = sq_side.ar > sq_side.br;
        if (sq_side.contain)
        begin
            p1_k_next    = '0;
            p1_den_next  = KW'(1);
            p1_dist_next = '0;
            p1_rad_next  = p1_awin_next ? RW'(sq_side.ar) : RW'(sq_side.br);
        end
        else
        begin
            p1_k_next    = ksum[KW-1:0];
            p1_den_next  = {sq_root, 1'b0};
            p1_dist_next = sq_root;
            p1_rad_next  = rsum[KW:1];
        end
    end

    // dividends and squared radii
    always_comb
    begin
        logic [CW+KW-1:0] prod;
        logic [2*RW-1:0]  rad2_full;
        for (int i = 0; i < AXES; i++)
        begin
            prod           = {{KW{1'b0}}, p1_side_reg.mag[i]} * {{CW{1'b0}}, p1_k_reg};
            p2_num_next[i] = NW'(prod) + NW'(p1_dist_reg);
        end
        rad2_full            = {{RW{1'b0}}, p1_rad_reg} * {{RW{1'b0}}, p1_rad_reg};
        p2_side_next.a       = p1_side_reg.a;
        p2_side_next.b       = p1_side_reg.b;
        p2_side_next.neg     = p1_side_reg.neg;
        p2_side_next.overlap = p1_side_reg.overlap;
        p2_side_next.contain = p1_side_reg.contain;
        p2_side_next.a_wins  = p1_awin_reg;
        p2_side_next.rad     = p1_rad_reg;
        p2_side_next.rad2    = rad2_full[D2W-1:0];
        p2_side_next.ar2     = {{CW{1'b0}}, p1_side_reg.ar} * {{CW{1'b0}}, p1_side_reg.ar};
    end

    bsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (p2_vld_reg),
        .num      (p2_num_reg),
        .den      (p2_den_reg),
        .in_side  (p2_side_reg),
        .out_vld  (dv_vld),
        .quo      (dv_quo),
        .out_side (dv_side)
    );

    // centre, clamps and growth
    always_comb
    begin
        logic signed [CW+1:0]  qs;
        logic signed [CW+1:0]  off;
        logic signed [CW+1:0]  c;
        logic [AXES-1:0][CW-1:0] m;
        logic                  clip;
        logic [D2W-1:0]        gfull;
        clip = 1'b0;
        for (int i = 0; i < AXES; i++)
        begin
            qs  = $signed({1'b0, dv_quo[i]});
            off = dv_side.neg[i] ? -qs : qs;
            c   = $signed({{2{dv_side.a[i][CW-1]}}, dv_side.a[i]}) + off;
            if (dv_side.contain)
            begin
                m[i] = dv_side.a_wins ? dv_side.a[i] : dv_side.b[i];
            end
            else if (c > $signed({3'b000, {(CW-1){1'b1}}}))
            begin
                m[i] = {1'b0, {(CW-1){1'b1}}};
                clip = 1'b1;
            end
            else if (c < $signed({3'b111, {(CW-1){1'b0}}}))
            begin
                m[i] = {1'b1, {(CW-1){1'b0}}};
                clip = 1'b1;
            end
            else
            begin
                m[i] = c[CW-1:0];
            end
        end
        gfull              = dv_side.rad2 - D2W'(dv_side.ar2);
        rsp_next.m_x       = m[0];
        rsp_next.m_y       = m[1];
        rsp_next.m_z       = m[2];
        rsp_next.m_r       = (dv_side.rad[RW-1:CW] != '0) ? '1 : dv_side.rad[CW-1:0];
        rsp_next.overlap   = dv_side.overlap;
        rsp_next.growth    = (gfull[D2W-1:GW] != '0) ? '1 : gfull[GW-1:0];
        rsp_next.saturated = clip || (dv_side.rad[RW-1:CW] != '0) || (gfull[D2W-1:GW] != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= sq_vld;
            p2_vld_reg <= p1_vld_reg;
            done_reg   <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_k_reg    <= p1_k_next;
        p1_den_reg  <= p1_den_next;
        p1_dist_reg <= p1_dist_next;
        p1_rad_reg  <= p1_rad_next;
        p1_awin_reg <= p1_awin_next;
        p1_side_reg <= sq_side;
        p2_num_reg  <= p2_num_next;
        p2_den_reg  <= p1_den_reg;
        p2_side_reg <= p2_side_next;
        rsp_reg     <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // centre never clips, so saturation comes from radius or growth
    `BSM_ASSERT_IMP(a_sat_src, clk, rst_n, done && rsp.saturated, (rsp.m_r == '1) || (rsp.growth == '1), "saturation without clipped radius or growth")

endmodule

[tb/bsm_checker.sv]
// ----------------------------------------------------------------------------
// bsm_checker
// Predicts each merged sphere from the accepted request beat and compares
// every response beat, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsm_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  bsm_pkg::in_beat_t   req,
    input  logic                done,
    input  bsm_pkg::out_beat_t  rsp,
    output int                  errors,
    output int                  pending,
    output int                  n_contain,
    output int                  n_merge,
    output int                  n_sat
);
    import bsm_pkg::*;

    out_beat_t merged_q[$];

    initial
    begin
        errors    = 0;
        n_contain = 0;
        n_merge   = 0;
        n_sat     = 0;
    end

    assign pending = merged_q.size();

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic out_beat_t merge_spheres(in_beat_t s);
        out_beat_t          o;
        logic signed [63:0] av[3];
        logic signed [63:0] bv[3];
        logic signed [63:0] dv[3];
        logic signed [63:0] c;
        logic [63:0]        mag, dist2, ar, br, rsum, rdiff, radius, growth;
        logic [63:0]        dist_v, k, den, q;
        logic signed [23:0] mv[3];
        logic               sat;
        sat   = 0;
        av[0] = s.a_x; av[1] = s.a_y; av[2] = s.a_z;
        bv[0] = s.b_x; bv[1] = s.b_y; bv[2] = s.b_z;
        ar    = s.a_r;
        br    = s.b_r;
        dist2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            dv[i] = bv[i] - av[i];
            mag   = dv[i] < 0 ? -dv[i] : dv[i];
            dist2 = dist2 + mag * mag;
        end
        rsum  = ar + br;
        rdiff = ar > br ? ar - br : br - ar;
        if (rdiff * rdiff >= dist2)
        begin
            n_contain++;
            for (int i = 0; i < 3; i++)
                mv[i] = ar > br ? av[i][23:0] : bv[i][23:0];
            radius = ar > br ? ar : br;
        end
        else
        begin
            n_merge++;
            dist_v = int_sqrt(dist2);
            k      = dist_v + br - ar;
            den    = dist_v * 2;
            radius = (dist_v + ar + br) >> 1;
            for (int i = 0; i < 3; i++)
            begin
                mag = dv[i] < 0 ? -dv[i] : dv[i];
                q   = (mag * k + dist_v) / den;
                c   = dv[i] < 0 ? av[i] - $signed(q) : av[i] + $signed(q);
                if (c > 64'sd8388607) begin c = 64'sd8388607; sat = 1; end
                if (c < -64'sd8388608) begin c = -64'sd8388608; sat = 1; end
                mv[i] = c[23:0];
            end
        end
        growth = radius * radius - ar * ar;
        if (growth > 64'hFFFF_FFFF_FFFF) begin growth = 64'hFFFF_FFFF_FFFF; sat = 1; end
        if (radius > 64'hFF_FFFF) begin radius = 64'hFF_FFFF; sat = 1; end
        if (sat)
            n_sat++;
        o.m_x       = mv[0];
        o.m_y       = mv[1];
        o.m_z       = mv[2];
        o.m_r       = radius[23:0];
        o.overlap   = dist2 < rsum * rsum;
        o.growth    = growth[47:0];
        o.saturated = sat;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        out_beat_t w;
        if (rst_n)
        begin
            if (start && !busy)
                merged_q.push_back(merge_spheres(req));
            if (done)
            begin
                if (merged_q.size() == 0)
                    report_mismatch("unexpected beat", rsp[63:0], 64'd0);
                else
                begin
                    w = merged_q.pop_front();
                    if (rsp.m_x !== w.m_x)
                        report_mismatch("m_x", 64'(rsp.m_x), 64'(w.m_x));
                    if (rsp.m_y !== w.m_y)
                        report_mismatch("m_y", 64'(rsp.m_y), 64'(w.m_y));
                    if (rsp.m_z !== w.m_z)
                        report_mismatch("m_z", 64'(rsp.m_z), 64'(w.m_z));
                    if (rsp.m_r !== w.m_r)
                        report_mismatch("m_r", 64'(rsp.m_r), 64'(w.m_r));
                    if (rsp.overlap !== w.overlap)
                        report_mismatch("overlap", 64'(rsp.overlap), 64'(w.overlap));
                    if (rsp.growth !== w.growth)
                        report_mismatch("growth", 64'(rsp.growth), 64'(w.growth));
                    if (rsp.saturated !== w.saturated)
                        report_mismatch("saturated", 64'(rsp.saturated), 64'(w.saturated));
                end
            end
        end
    end

endmodule

[tb/tb_bounding_sphere_merge_unit.sv]
// ----------------------------------------------------------------------------
// tb_bounding_sphere_merge_unit
// Drives sphere pairs into the merge unit: directed corners (containment,
// equal and identical spheres, extreme coordinates and radii, saturation),
// then random pairs of mixed scale, with random idle gaps except in one back-to-back run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bounding_sphere_merge_unit;
    import bsm_pkg::*;

    localparam int LATENCY = 57;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_beat_t  req;
    logic      done;
    out_beat_t rsp;
    int        errors, pending, n_contain, n_merge, n_sat;

    bounding_sphere_merge_unit dut (.clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
                                    .req(req), .done(done), .rsp(rsp));

    bsm_checker chk (.clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
                     .done(done), .rsp(rsp), .errors(errors), .pending(pending),
                     .n_contain(n_contain), .n_merge(n_merge), .n_sat(n_sat));

    always
    begin
        clk = 1'b1; #1;
        clk = 1'b0; #1;
    end

    function automatic logic [23:0] rand_field(int scale);
        logic [23:0] v;
        v = 24'($urandom);
        case (scale)
            0: v = 24'($signed(v[7:0]));
            1: v = 24'($signed(v[15:0]));
            default: ;
        endcase
        return v;
    endfunction

    function automatic in_beat_t rand_pair();
        in_beat_t s;
        int       sc;
        sc    = $urandom_range(0, 3);
        s.a_x = rand_field(sc); s.a_y = rand_field(sc); s.a_z = rand_field(sc);
        s.b_x = rand_field(sc); s.b_y = rand_field(sc); s.b_z = rand_field(sc);
        s.a_r = sc == 2 ? rand_field(2) : rand_field(sc) & 24'h7F_FFFF;
        s.b_r = $urandom_range(0, 3) == 0 ? rand_field(2) : s.a_r ^ rand_field(0);
        if ($urandom_range(0, 15) == 0)
            s.b_r = s.a_r;
        if ($urandom_range(0, 15) == 0)
        begin
            s.b_x = s.a_x; s.b_y = s.a_y; s.b_z = s.a_z;
        end
        return s;
    endfunction

    task automatic send(in_beat_t s, bit calm);
        while (!calm && $urandom_range(0, 99) < 7)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic sphere(output in_beat_t s, input logic [23:0] ax, ay, az, ar,
                          bx, by, bz, br);
        s = '{ax, ay, az, ar, bx, by, bz, br};
    endtask

    initial
    begin
        in_beat_t    s;
        in_beat_t    dir[$];
        int          waited;
        start = 1'b0;
        req   = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sphere(s, 0, 0, 0, 0, 0, 0, 0, 0);                              dir.push_back(s);
        sphere(s, 1, 2, 3, 100, 1, 2, 3, 100);                          dir.push_back(s);
        sphere(s, 0, 0, 0, 5000, 10, 0, 0, 100);                        dir.push_back(s);
        sphere(s, 0, 0, 0, 100, 10, 0, 0, 5000);                        dir.push_back(s);
        sphere(s, 0, 0, 0, 300, 300, 0, 0, 0);                          dir.push_back(s);
        sphere(s, 0, 0, 0, 4096, 8192, 0, 0, 4096);                     dir.push_back(s);
        sphere(s, 0, 0, 0, 4096, 16384, 0, 0, 4096);                    dir.push_back(s);
        sphere(s, 24'h80_0000, 24'h80_0000, 24'h80_0000, 24'hFF_FFFF,
               24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 24'hFF_FFFF);    dir.push_back(s);
        sphere(s, 24'h80_0000, 24'h80_0000, 24'h80_0000, 0,
               24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 24'hFF_FFFF);    dir.push_back(s);
        sphere(s, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF, 24'hFF_FFFF,
               24'h80_0000, 24'h7F_FFFF, 24'h80_0000, 0);              dir.push_back(s);
        sphere(s, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1, 1, 1, 1, 1); dir.push_back(s);
        sphere(s, 24'h80_0000, 0, 0, 24'hFF_FFFF, 24'h7F_FFFF, 0, 0, 0); dir.push_back(s);
        sphere(s, 0, 24'h80_0000, 0, 0, 0, 24'h7F_FFFF, 0, 24'hFF_FFFF); dir.push_back(s);
        sphere(s, 24'h55_5555, 24'hAA_AAAA, 24'h55_5555, 24'hAA_AAAA,
               24'hAA_AAAA, 24'h55_5555, 24'hAA_AAAA, 24'h55_5555);    dir.push_back(s);
        sphere(s, 3, 4, 0, 2, 0, 0, 0, 3);                              dir.push_back(s);
        sphere(s, -7, 5, -3, 1, 9, -2, 6, 1);                           dir.push_back(s);
        foreach (dir[i])
            send(dir[i], 1'b0);

        for (int n = 0; n < 1900; n++)
            send(rand_pair(), n >= 700 && n < 1000);
        start <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 10 * LATENCY)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY) @(posedge clk);
        $display("covered %0d containment and %0d merge pairs, %0d with saturation",
                 n_contain, n_merge, n_sat);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #200000;
        $display("tb: failure");
        $finish;
    end

endmodule
